// ----- rtl/sdmg_pkg.sv -----
package sdmg_pkg;

    // Port field widths, fixed by the interface
    localparam int DIVISOR_W = 32;
    localparam int MAGIC_W   = 32;
    localparam int SHIFT_W   = 5;

    // Default arithmetic width of the magic computation
    localparam int WIDTH_DEF = 32;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOD  = 6'b000010,
        S_ANC  = 6'b000100,
        S_DIV  = 6'b001000,
        S_LOOP = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

// ----- rtl/sdmg_step.sv -----
// One restoring division step: shift in a dividend bit, compare, subtract.
// Also serves the doubling step (dividend bit 0).
module sdmg_step #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] i_quot,
    input  logic [WIDTH-1:0] i_rem,
    input  logic [WIDTH-1:0] i_dvs,
    input  logic             i_bit,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);

    logic [WIDTH:0] rem_sh;
    logic [WIDTH:0] rem_sub;
    logic           ge;

    always_comb begin
        rem_sh  = {i_rem, i_bit};
        rem_sub = rem_sh - {1'b0, i_dvs};
        ge      = (rem_sh >= {1'b0, i_dvs});
        o_rem   = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        o_quot  = {i_quot[WIDTH-2:0], ge};
    end

endmodule

// ----- rtl/signed_div_magic_gen.sv -----
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------
// divisor  | in        | i_valid / o_ready   | i_divisor
// magic    | out       | o_valid / i_ready   | o_magic, o_shift_amount, o_invalid
//
// After a divisor is taken: WIDTH steps for the remainder that gives |nc| (S_MOD), one state to
// form |nc| (S_ANC), WIDTH steps for both first quotients (S_DIV), k doublings with a stop test
// after each (S_LOOP, k = 1..WIDTH), then S_DONE loads the result once the output is free.
// Two restoring-step units do one bit per cycle each. Divisors 0, 1 and -1 skip to S_DONE.
// Reset (i_rst_n low, synchronous) returns to idle and drops o_valid. The result word sits in
// an output register, so a new divisor is taken while the previous result waits for i_ready.
module signed_div_magic_gen
    import sdmg_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [DIVISOR_W-1:0] i_divisor,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [MAGIC_W-1:0]  o_magic,
    output logic [SHIFT_W-1:0]         o_shift_amount,
    output logic                       o_invalid
);

    localparam int CW = $clog2(WIDTH + 1);

    t_state r_state, n_state;

    logic [WIDTH-1:0] r_ad, n_ad;
    logic [WIDTH-1:0] r_anc, n_anc;
    logic [WIDTH-1:0] r_dvd, n_dvd;
    logic [WIDTH-1:0] r_q1, n_q1, r_r1, n_r1;
    logic [WIDTH-1:0] r_q2, n_q2, r_r2, n_r2;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_neg, n_neg;
    logic             r_inv, n_inv;

    logic               r_valid, n_valid;
    logic [MAGIC_W-1:0] r_magic, n_magic;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic               r_oinv, n_oinv;

    logic [WIDTH-1:0] d_w;
    logic [WIDTH-1:0] smin;
    logic [WIDTH-1:0] anc_raw;
    logic [WIDTH-1:0] delta;
    logic [WIDTH-1:0] mag_w;
    logic             stop;
    logic             out_free;

    // step units: lane A is shared, doing |t| mod |d|, then the |nc| quotient; lane B divides by |d|
    logic [WIDTH-1:0] a_dvs, a_q, a_r;
    logic             a_bit;
    logic [WIDTH-1:0] b_q, b_r;
    logic             b_bit;

    sdmg_step #(.WIDTH(WIDTH)) u_step_a (
        .i_quot (r_q1),
        .i_rem  (r_r1),
        .i_dvs  (a_dvs),
        .i_bit  (a_bit),
        .o_quot (a_q),
        .o_rem  (a_r)
    );

    sdmg_step #(.WIDTH(WIDTH)) u_step_b (
        .i_quot (r_q2),
        .i_rem  (r_r2),
        .i_dvs  (r_ad),
        .i_bit  (b_bit),
        .o_quot (b_q),
        .o_rem  (b_r)
    );

    always_comb begin
        d_w      = WIDTH'($unsigned(i_divisor));
        smin     = WIDTH'(1) << (WIDTH - 1);
        anc_raw  = smin - WIDTH'(1) + WIDTH'(r_neg) - r_r1;
        delta    = r_ad - r_r2;
        stop     = !((r_q1 < delta) || ((r_q1 == delta) && (r_r1 == '0)));
        mag_w    = r_neg ? (WIDTH'(0) - (r_q2 + WIDTH'(1))) : (r_q2 + WIDTH'(1));
        out_free = !r_valid || i_ready;

        a_dvs = (r_state == S_MOD) ? r_ad : r_anc;
        // dividend 2^(WIDTH-1) has only its top bit set
        a_bit = (r_state == S_MOD) ? r_dvd[WIDTH-1]
                                   : ((r_state == S_DIV) && (r_cnt == '0));
        b_bit = (r_state == S_DIV) && (r_cnt == '0);
    end

    always_comb begin
        n_state = r_state;
        n_ad    = r_ad;
        n_anc   = r_anc;
        n_dvd   = r_dvd;
        n_q1    = r_q1;
        n_r1    = r_r1;
        n_q2    = r_q2;
        n_r2    = r_r2;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_inv   = r_inv;
        n_valid = r_valid;
        n_magic = r_magic;
        n_shift = r_shift;
        n_oinv  = r_oinv;

        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_neg   = d_w[WIDTH-1];
                    n_ad    = d_w[WIDTH-1] ? (WIDTH'(0) - d_w) : d_w;
                    n_dvd   = smin + WIDTH'(d_w[WIDTH-1]);
                    n_q1    = '0;
                    n_r1    = '0;
                    n_cnt   = '0;
                    n_inv   = (d_w == '0) || (d_w == WIDTH'(1)) || (d_w == '1);
                    n_state = ((d_w == '0) || (d_w == WIDTH'(1)) || (d_w == '1))
                              ? S_DONE : S_MOD;
                end
            end
            S_MOD: begin
                n_r1  = a_r;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(WIDTH - 1)) begin
                    n_state = S_ANC;
                end
            end
            S_ANC: begin
                n_anc   = (anc_raw == '0) ? WIDTH'(1) : anc_raw;
                n_q1    = '0;
                n_r1    = '0;
                n_q2    = '0;
                n_r2    = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_q1  = a_q;
                n_r1  = a_r;
                n_q2  = b_q;
                n_r2  = b_r;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(WIDTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                // test the word from the previous doubling before the next one
                if (((r_cnt != '0) && stop) || (r_cnt == CW'(WIDTH))) begin
                    n_state = S_DONE;
                end else begin
                    n_q1  = a_q;
                    n_r1  = a_r;
                    n_q2  = b_q;
                    n_r2  = b_r;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_oinv  = r_inv;
                    n_magic = r_inv ? '0 : MAGIC_W'(mag_w);
                    n_shift = r_inv ? '0 : SHIFT_W'(r_cnt - CW'(1));
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ad    <= n_ad;
        r_anc   <= n_anc;
        r_dvd   <= n_dvd;
        r_q1    <= n_q1;
        r_r1    <= n_r1;
        r_q2    <= n_q2;
        r_r2    <= n_r2;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_inv   <= n_inv;
        r_magic <= n_magic;
        r_shift <= n_shift;
        r_oinv  <= n_oinv;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_valid;
    assign o_magic        = r_magic;
    assign o_shift_amount = r_shift;
    assign o_invalid      = r_oinv;

endmodule
